FILE: sv/cpfa_pkg.sv
//------------------------------------------------------------------------------
// cpfa_pkg: shared types and helpers for the channel parameter field access
// Word sizes, the shift unit control group and the field mask helper.
//------------------------------------------------------------------------------
`default_nettype none

package cpfa_pkg;

  localparam int WORD_W = 32;
  localparam int PAIR_W = 64;
  localparam int OFS_W  = 5;
  localparam int SIZE_W = 6;

  typedef enum logic {
    SH_LEFT  = 1'b0,
    SH_RIGHT = 1'b1
  } shift_dir_t;

  typedef struct packed {
    shift_dir_t       dir;
    logic [OFS_W-1:0] amount;
  } shift_ctl_t;

  function automatic logic [WORD_W-1:0] size_mask(input logic [SIZE_W-1:0] size);
    logic [WORD_W-1:0] m;
    if (size >= SIZE_W'(WORD_W)) begin
      m = '1;
    end else begin
      m = (WORD_W'(1) << size) - WORD_W'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: sv/cpfa_ram.sv
//------------------------------------------------------------------------------
// cpfa_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
//------------------------------------------------------------------------------
`default_nettype none

module cpfa_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 640,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/cpfa_shift.sv
//------------------------------------------------------------------------------
// cpfa_shift: shared 64-bit shift unit
// Left shift for mask and value placement, right shift for field extraction.
//------------------------------------------------------------------------------
`default_nettype none

module cpfa_shift (
  input  cpfa_pkg::shift_ctl_t              ctl,
  input  logic [cpfa_pkg::PAIR_W-1:0]       din,
  output logic [cpfa_pkg::PAIR_W-1:0]       dout
);
  import cpfa_pkg::*;

  always_comb begin
    unique case (ctl.dir)
      SH_LEFT:  dout = din << ctl.amount;
      SH_RIGHT: dout = din >> ctl.amount;
      default:  dout = din;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/channel_param_field_access.sv
//------------------------------------------------------------------------------
// channel_param_field_access: per-channel parameter store with a field port
// Reads or writes a 1..32 bit field of a channel's parameter rows.
//------------------------------------------------------------------------------
// channel  signals                                         direction
// request  start, req_type, channel, field_position,        in
//          field_size, write_value
// result   busy, done, read_value, range_error              out
//
// A transaction is taken when start is high and busy is low. The row is found
// by repeated subtraction of ROW_BITS (at most ROWS_PER_CHANNEL times). done
// pulses after the check for a refused or empty field; a read instead fetches
// the field's one or two words and extracts the field, and a write does the
// same reads, then writes back each word that the field touches.
// After reset the store is cleared, one word a cycle, NUM_CHANNELS *
// ROWS_PER_CHANNEL * ceil(ROW_BITS/32) words (640 by default), busy high.
// The receiver cannot stall; done holds for exactly one cycle.
//------------------------------------------------------------------------------
`default_nettype none

module channel_param_field_access #(
  parameter int NUM_CHANNELS     = 64,
  parameter int ROWS_PER_CHANNEL = 2,
  parameter int ROW_BITS         = 160
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [5:0]  channel,
  input  logic [8:0]  field_position,
  input  logic [5:0]  field_size,
  input  logic [31:0] write_value,
  output logic        done,
  output logic [31:0] read_value,
  output logic        range_error
);
  import cpfa_pkg::*;

  localparam int ROW_WORDS = (ROW_BITS + WORD_W - 1) / WORD_W;
  localparam int DEPTH     = NUM_CHANNELS * ROWS_PER_CHANNEL * ROW_WORDS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W     = $clog2(ROWS_PER_CHANNEL + 1);
  localparam int CALC_W    = 16;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_CHECK = 9'b000001000,
    S_RD_LO = 9'b000010000,
    S_RD_HI = 9'b000100000,
    S_CAP   = 9'b001000000,
    S_WR_LO = 9'b010000000,
    S_WR_HI = 9'b100000000
  } state_t;

  state_t state;

  logic [ADDR_W-1:0] clr_cnt;
  logic              req_w;
  logic [5:0]        chan_r;
  logic [8:0]        rem;
  logic [ROW_W-1:0]  row;
  logic [5:0]        size_r;
  logic [31:0]       value_r;
  logic [31:0]       mask_r;
  logic [OFS_W-1:0]  ofs_r;
  logic              two_r;
  logic [ADDR_W-1:0] lo_addr;
  logic [ADDR_W-1:0] hi_addr;
  logic [31:0]       lo_word;
  logic [31:0]       hi_word;
  logic [PAIR_W-1:0] m_pair;
  logic [PAIR_W-1:0] v_pair;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;

  shift_ctl_t        sh_ctl;
  logic [PAIR_W-1:0] sh_din;
  logic [PAIR_W-1:0] sh_dout;

  logic              refused;
  logic              two_next;
  logic [CALC_W-1:0] addr_calc;
  logic [31:0]       hi_sel;

  assign busy    = (state != S_IDLE);
  assign hi_addr = lo_addr + 1'b1;
  assign hi_sel  = two_r ? ram_rdata : 32'd0;

  always_comb begin
    refused = ({1'b0, chan_r} >= 7'(NUM_CHANNELS)) ||
              (row == ROW_W'(ROWS_PER_CHANNEL)) ||
              (size_r > 6'd32) ||
              (({1'b0, rem} + {4'd0, size_r}) > 10'(ROW_BITS));
    two_next  = ({2'd0, rem[4:0]} + {1'b0, size_r}) > 7'd32;
    addr_calc = (CALC_W'(chan_r) * CALC_W'(ROWS_PER_CHANNEL) + CALC_W'(row)) *
                CALC_W'(ROW_WORDS) + CALC_W'(rem[8:5]);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = lo_addr;
    ram_wdata = 32'd0;
    ram_raddr = lo_addr;
    sh_ctl    = '{dir: SH_LEFT, amount: ofs_r};
    sh_din    = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      S_RD_LO: begin
        sh_din = {32'd0, mask_r};
      end
      S_RD_HI: begin
        ram_raddr = two_r ? hi_addr : lo_addr;
        sh_din    = {32'd0, value_r & mask_r};
      end
      S_CAP: begin
        sh_ctl = '{dir: SH_RIGHT, amount: ofs_r};
        sh_din = {hi_sel, lo_word};
      end
      S_WR_LO: begin
        ram_we    = 1'b1;
        ram_wdata = (lo_word & ~m_pair[31:0]) | v_pair[31:0];
      end
      S_WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_addr;
        ram_wdata = (hi_word & ~m_pair[63:32]) | v_pair[63:32];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem >= 9'(ROW_BITS) && row != ROW_W'(ROWS_PER_CHANNEL)) begin
            state <= S_DIV;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (refused || size_r == 6'd0) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_RD_LO;
          end
        end
        S_RD_LO: state <= S_RD_HI;
        S_RD_HI: state <= S_CAP;
        S_CAP: begin
          if (req_w) begin
            state <= S_WR_LO;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_WR_LO: begin
          if (two_r) begin
            state <= S_WR_HI;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_WR_HI: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_w   <= req_type;
          chan_r  <= channel;
          rem     <= field_position;
          row     <= '0;
          size_r  <= field_size;
          value_r <= write_value;
        end
      end
      S_DIV: begin
        if (rem >= 9'(ROW_BITS) && row != ROW_W'(ROWS_PER_CHANNEL)) begin
          rem <= rem - 9'(ROW_BITS);
          row <= row + 1'b1;
        end
      end
      S_CHECK: begin
        ofs_r       <= rem[4:0];
        two_r       <= two_next;
        mask_r      <= size_mask(size_r);
        lo_addr     <= addr_calc[ADDR_W-1:0];
        read_value  <= 32'd0;
        range_error <= refused;
      end
      S_RD_LO: m_pair <= sh_dout;
      S_RD_HI: begin
        v_pair  <= sh_dout;
        lo_word <= ram_rdata;
      end
      S_CAP: begin
        hi_word <= hi_sel;
        if (!req_w) begin
          read_value <= sh_dout[31:0] & mask_r;
        end
      end
      default: begin
      end
    endcase
  end

  cpfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  cpfa_shift u_shift (
    .ctl (sh_ctl),
    .din (sh_din),
    .dout(sh_dout)
  );

endmodule

`default_nettype wire

FILE: sv/cpfa_checker.sv
//------------------------------------------------------------------------------
// cpfa_checker: port-level checks for channel_param_field_access
// Strobe spacing, busy after accept, done only while idle and refused-result contents.
//------------------------------------------------------------------------------
`default_nettype none

module cpfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] read_value,
  input logic        range_error
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low after accepted transaction");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while still busy");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    done && range_error |-> read_value == 32'd0)
    else $error("refused transaction returned data");

endmodule

bind channel_param_field_access cpfa_checker u_cpfa_checker (.*);

`default_nettype wire
